// ===== design/lid_pkg.sv =====
package lid_pkg;

    localparam int LID_QUEUE_DEPTH = 4;
    localparam int LID_IN_W        = 160;
    localparam int LID_OUT_W       = 104;

    localparam logic [31:0] LID_TOL_RESET = 32'd1307819;
    localparam logic [31:0] LID_POS_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] LID_NEG_MAX   = 32'h8000_0000;
    localparam logic [31:0] LID_U_MAX     = 32'hFFFF_FFFF;

    typedef struct packed {
        logic signed [16:0] a1;
        logic signed [16:0] b1;
        logic signed [32:0] c1;
        logic signed [16:0] a2;
        logic signed [16:0] b2;
        logic signed [32:0] c2;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
    } t_coef;

endpackage

// ===== design/line_intersect_and_distance.sv =====
// Channel  Dir  Ports                         Content
// s_axis   in   tvalid tready tdata[159:0]    one request: two lines and a query point
// m_axis   out  tvalid tready tdata[103:0]    intersection, parallel flag, distance
// cfg      in   i_cfg_we i_cfg_wdata[31:0]    tolerance_squared
//
// One request per cycle while the queue is not full. A request passes from the queue
// through stages A to E, then the 64-step distance divider followed by the 32-step
// square root, then the output register.
// A stalled m_axis freezes the back pipeline; the queue keeps taking requests until full.
// i_rst_n is synchronous; it empties the queue and pipeline and restores the tolerance.
module line_intersect_and_distance #(
    parameter int QUEUE_DEPTH = lid_pkg::LID_QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // first_ax, first_ay, first_bx, first_by, second_ax, second_ay,
    // second_bx, second_by, query_x, query_y
    input  logic [lid_pkg::LID_IN_W-1:0]  s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // cross_x, cross_y, parallel, point_distance, overflowed, zero fill
    output logic [lid_pkg::LID_OUT_W-1:0] m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [31:0]                   i_cfg_wdata
);
    import lid_pkg::*;

    logic [31:0] r_tol;
    logic        w_push, w_full, w_qvalid, w_pop;
    t_coef       w_fcoef, w_qcoef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= LID_TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    lid_front u_front (
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .i_full  (w_full),
        .o_ready (s_axis_tready),
        .o_push  (w_push),
        .o_coef  (w_fcoef)
    );

    lid_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_fcoef),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_qvalid),
        .o_data  (w_qcoef)
    );

    lid_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tol    (r_tol),
        .i_valid  (w_qvalid),
        .i_coef   (w_qcoef),
        .o_pop    (w_pop),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .i_tready (m_axis_tready)
    );

    a_par_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[64] |->
            m_axis_tdata[31:0] == LID_POS_MAX && m_axis_tdata[63:32] == LID_POS_MAX)
        else $error("parallel result without saturated intersection");

    a_tol_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(i_cfg_we) |-> r_tol == $past(i_cfg_wdata))
        else $error("tolerance register missed a write");

endmodule

// ===== design/lid_front.sv =====
module lid_front (
    input  logic                          i_valid,
    input  logic [lid_pkg::LID_IN_W-1:0]  i_data,
    input  logic                          i_full,
    output logic                          o_ready,
    output logic                          o_push,
    output lid_pkg::t_coef                o_coef
);
    import lid_pkg::*;

    logic signed [15:0] w_f [10];

    for (genvar k = 0; k < 10; k++) begin : g_field
        assign w_f[k] = i_data[16*k +: 16];
    end

    always_comb begin
        // first line
        if (w_f[0] == w_f[2]) begin
            o_coef.a1 = 17'sd256;
            o_coef.b1 = '0;
            o_coef.c1 = -(33'(w_f[0]) <<< 8);
        end else begin
            o_coef.a1 = 17'(w_f[3]) - 17'(w_f[1]);
            o_coef.b1 = 17'(w_f[0]) - 17'(w_f[2]);
            o_coef.c1 = 33'(w_f[1]) * 33'(w_f[2]) - 33'(w_f[3]) * 33'(w_f[0]);
        end
        // second line
        if (w_f[4] == w_f[6]) begin
            o_coef.a2 = 17'sd256;
            o_coef.b2 = '0;
            o_coef.c2 = -(33'(w_f[4]) <<< 8);
        end else begin
            o_coef.a2 = 17'(w_f[7]) - 17'(w_f[5]);
            o_coef.b2 = 17'(w_f[4]) - 17'(w_f[6]);
            o_coef.c2 = 33'(w_f[5]) * 33'(w_f[6]) - 33'(w_f[7]) * 33'(w_f[4]);
        end
        o_coef.qx = w_f[8];
        o_coef.qy = w_f[9];
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

endmodule

// ===== design/lid_queue.sv =====
module lid_queue #(
    parameter int DEPTH = lid_pkg::LID_QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lid_pkg::t_coef i_data,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output lid_pkg::t_coef o_data
);
    import lid_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_coef         r_mem [DEPTH];
    logic [IW-1:0] r_wr;
    logic [IW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic [IW-1:0] n_wr;
    logic [IW-1:0] n_rd;

    assign n_wr    = (r_wr == IW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd    = (r_rd == IW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== design/lid_div.sv =====
module lid_div #(
    parameter int NW = 58,
    parameter int DW = 34,
    parameter int QW = 32,
    parameter int SW = 2
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_tag,
    output logic [QW-1:0] o_quot,
    output logic [SW-1:0] o_tag
);
    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_nq  [QW];
    logic [DW-1:0] r_den [QW];
    logic [SW-1:0] r_tag [QW];
    logic [DW-1:0] w_rem [QW+1];
    logic [QW-1:0] w_nq  [QW+1];
    logic [DW-1:0] w_den [QW+1];
    logic [SW-1:0] w_tag [QW+1];
    logic [DW-1:0] n_rem [QW];
    logic [QW-1:0] n_nq  [QW];

    assign w_rem[0] = DW'(i_num[NW-1:QW]);
    assign w_nq[0]  = i_num[QW-1:0];
    assign w_den[0] = i_den;
    assign w_tag[0] = i_tag;

    for (genvar k = 1; k <= QW; k++) begin : g_link
        assign w_rem[k] = r_rem[k-1];
        assign w_nq[k]  = r_nq[k-1];
        assign w_den[k] = r_den[k-1];
        assign w_tag[k] = r_tag[k-1];
    end

    always_comb begin
        logic [DW:0] sh;
        logic        ge;
        for (int k = 0; k < QW; k++) begin
            sh       = {w_rem[k], w_nq[k][QW-1]};
            ge       = (sh >= {1'b0, w_den[k]});
            n_rem[k] = ge ? DW'(sh - {1'b0, w_den[k]}) : sh[DW-1:0];
            n_nq[k]  = {w_nq[k][QW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QW; k++) begin
                r_rem[k] <= n_rem[k];
                r_nq[k]  <= n_nq[k];
                r_den[k] <= w_den[k];
                r_tag[k] <= w_tag[k];
            end
        end
    end

    assign o_quot = w_nq[QW];
    assign o_tag  = w_tag[QW];

endmodule

// ===== design/lid_sqrt.sv =====
module lid_sqrt #(
    parameter int VW = 64,
    parameter int SW = 2
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [VW-1:0]     i_val,
    input  logic [SW-1:0]     i_tag,
    output logic [VW/2-1:0]   o_root,
    output logic [SW-1:0]     o_tag
);
    localparam int RW = VW / 2;

    logic [RW+1:0] r_rem  [RW];
    logic [RW-1:0] r_root [RW];
    logic [VW-1:0] r_v    [RW];
    logic [SW-1:0] r_tag  [RW];
    logic [RW+1:0] w_rem  [RW+1];
    logic [RW-1:0] w_root [RW+1];
    logic [VW-1:0] w_v    [RW+1];
    logic [SW-1:0] w_tag  [RW+1];
    logic [RW+1:0] n_rem  [RW];
    logic [RW-1:0] n_root [RW];

    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_v[0]    = i_val;
    assign w_tag[0]  = i_tag;

    for (genvar k = 1; k <= RW; k++) begin : g_link
        assign w_rem[k]  = r_rem[k-1];
        assign w_root[k] = r_root[k-1];
        assign w_v[k]    = r_v[k-1];
        assign w_tag[k]  = r_tag[k-1];
    end

    always_comb begin
        logic [RW+1:0] sh;
        logic [RW+1:0] trial;
        logic          ge;
        for (int k = 0; k < RW; k++) begin
            sh        = {w_rem[k][RW-1:0], w_v[k][VW-1 -: 2]};
            trial     = {w_root[k], 2'b01};
            ge        = (sh >= trial);
            n_rem[k]  = ge ? sh - trial : sh;
            n_root[k] = {w_root[k][RW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < RW; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_v[k]    <= {w_v[k][VW-3:0], 2'b00};
                r_tag[k]  <= w_tag[k];
            end
        end
    end

    assign o_root = w_root[RW];
    assign o_tag  = w_tag[RW];

endmodule

// ===== design/lid_back.sv =====
module lid_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [31:0]                   i_tol,
    input  logic                          i_valid,
    input  lid_pkg::t_coef                i_coef,
    output logic                          o_pop,
    output logic                          o_tvalid,
    output logic [lid_pkg::LID_OUT_W-1:0] o_tdata,
    input  logic                          i_tready
);
    import lid_pkg::*;

    localparam int LAT = 5 + 64 + 32;

    typedef struct packed {
        logic [57:0] nxm;
        logic [57:0] nym;
        logic [33:0] detm;
        logic        sx;
        logic        sy;
        logic        ovx;
        logic        ovy;
        logic        par;
        logic        dov;
    } t_dtag;

    logic w_en;
    logic r_vld [LAT];
    logic r_o_valid;
    logic [LID_OUT_W-1:0] r_o_data;

    // stage A: products
    logic signed [33:0] r_a_a1b2, r_a_a2b1, r_a_a1sq, r_a_b1sq, r_a_a2sq, r_a_b2sq;
    logic signed [49:0] r_a_b1c2, r_a_b2c1, r_a_c1a2, r_a_c2a1;
    logic signed [32:0] r_a_a1qx, r_a_b1qy, r_a_c1;
    // stage B: sums
    logic [33:0]        r_b_n1, r_b_n2;
    logic signed [34:0] r_b_det, r_b_dn;
    logic signed [58:0] r_b_nx, r_b_ny;
    // stage C: magnitudes and squares
    logic [67:0] r_c_p, r_c_dsq, r_c_dsq2;
    logic [33:0] r_c_detm, r_c_n1;
    logic [57:0] r_c_nxm, r_c_nym;
    logic        r_c_detz, r_c_sx, r_c_sy;
    // stage D: tolerance products and range checks
    logic [65:0] r_d_pl, r_d_ph;
    logic [67:0] r_d_dsq, r_d_dsq2;
    logic [33:0] r_d_detm, r_d_n1;
    logic [57:0] r_d_nxm, r_d_nym;
    logic        r_d_detz, r_d_sx, r_d_sy, r_d_ovx, r_d_ovy, r_d_dov;
    // stage E: parallel test
    logic [67:0] r_e_dsq2;
    logic [33:0] r_e_n1;
    t_dtag       r_e_tag;

    logic [33:0]  w_detm, w_dnm;
    logic [99:0]  w_rhs;
    logic [63:0]  w_dq;
    t_dtag        w_dtag;
    logic [31:0]  w_root, w_qx, w_qy;
    logic [1:0]   w_stag, w_xtag, w_ytag;
    logic         w_ovfx, w_ovfy, w_ovf;
    logic [31:0]  w_cx, w_cy, w_dist;

    assign w_en     = !r_o_valid || i_tready;
    assign o_pop    = w_en && i_valid;
    assign o_tvalid = r_o_valid;
    assign o_tdata  = r_o_data;

    assign w_detm = r_b_det[34] ? 34'(-r_b_det) : 34'(r_b_det);
    assign w_dnm  = r_b_dn[34]  ? 34'(-r_b_dn)  : 34'(r_b_dn);
    assign w_rhs  = {34'd0, r_d_pl} + {r_d_ph, 34'd0};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_a1b2 <= 34'(i_coef.a1) * 34'(i_coef.b2);
            r_a_a2b1 <= 34'(i_coef.a2) * 34'(i_coef.b1);
            r_a_a1sq <= 34'(i_coef.a1) * 34'(i_coef.a1);
            r_a_b1sq <= 34'(i_coef.b1) * 34'(i_coef.b1);
            r_a_a2sq <= 34'(i_coef.a2) * 34'(i_coef.a2);
            r_a_b2sq <= 34'(i_coef.b2) * 34'(i_coef.b2);
            r_a_b1c2 <= 50'(i_coef.b1) * 50'(i_coef.c2);
            r_a_b2c1 <= 50'(i_coef.b2) * 50'(i_coef.c1);
            r_a_c1a2 <= 50'(i_coef.c1) * 50'(i_coef.a2);
            r_a_c2a1 <= 50'(i_coef.c2) * 50'(i_coef.a1);
            r_a_a1qx <= 33'(i_coef.a1) * 33'(i_coef.qx);
            r_a_b1qy <= 33'(i_coef.b1) * 33'(i_coef.qy);
            r_a_c1   <= i_coef.c1;

            r_b_n1  <= 34'(r_a_a1sq + r_a_b1sq);
            r_b_n2  <= 34'(r_a_a2sq + r_a_b2sq);
            r_b_det <= 35'(r_a_a1b2) - 35'(r_a_a2b1);
            r_b_nx  <= (59'(r_a_b1c2) - 59'(r_a_b2c1)) <<< 8;
            r_b_ny  <= (59'(r_a_c1a2) - 59'(r_a_c2a1)) <<< 8;
            r_b_dn  <= 35'(r_a_a1qx) + 35'(r_a_b1qy) + 35'(r_a_c1);

            r_c_p    <= 68'(r_b_n1) * 68'(r_b_n2);
            r_c_dsq  <= 68'(w_detm) * 68'(w_detm);
            r_c_dsq2 <= 68'(w_dnm) * 68'(w_dnm);
            r_c_detm <= w_detm;
            r_c_n1   <= r_b_n1;
            r_c_nxm  <= r_b_nx[58] ? 58'(-r_b_nx) : 58'(r_b_nx);
            r_c_nym  <= r_b_ny[58] ? 58'(-r_b_ny) : 58'(r_b_ny);
            r_c_detz <= (r_b_det == '0);
            r_c_sx   <= r_b_nx[58] ^ r_b_det[34];
            r_c_sy   <= r_b_ny[58] ^ r_b_det[34];

            r_d_pl   <= 66'(r_c_p[33:0]) * 66'(i_tol);
            r_d_ph   <= 66'(r_c_p[67:34]) * 66'(i_tol);
            r_d_dsq  <= r_c_dsq;
            r_d_dsq2 <= r_c_dsq2;
            r_d_detm <= r_c_detm;
            r_d_n1   <= r_c_n1;
            r_d_nxm  <= r_c_nxm;
            r_d_nym  <= r_c_nym;
            r_d_detz <= r_c_detz;
            r_d_sx   <= r_c_sx;
            r_d_sy   <= r_c_sy;
            r_d_ovx  <= (34'(r_c_nxm[57:32]) >= r_c_detm);
            r_d_ovy  <= (34'(r_c_nym[57:32]) >= r_c_detm);
            r_d_dov  <= (34'(r_c_dsq2[67:48]) >= r_c_n1);

            r_e_dsq2     <= r_d_dsq2;
            r_e_n1       <= r_d_n1;
            r_e_tag.nxm  <= r_d_nxm;
            r_e_tag.nym  <= r_d_nym;
            r_e_tag.detm <= r_d_detm;
            r_e_tag.sx   <= r_d_sx;
            r_e_tag.sy   <= r_d_sy;
            r_e_tag.ovx  <= r_d_ovx;
            r_e_tag.ovy  <= r_d_ovy;
            r_e_tag.par  <= r_d_detz || ({r_d_dsq, 32'd0} < w_rhs);
            r_e_tag.dov  <= r_d_dov;
        end
    end

    lid_div #(.NW(84), .DW(34), .QW(64), .SW($bits(t_dtag))) u_ddiv (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  ({r_e_dsq2, 16'd0}),
        .i_den  (r_e_n1),
        .i_tag  (r_e_tag),
        .o_quot (w_dq),
        .o_tag  (w_dtag)
    );

    lid_sqrt #(.VW(64), .SW(2)) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  (w_dq),
        .i_tag  ({w_dtag.par, w_dtag.dov}),
        .o_root (w_root),
        .o_tag  (w_stag)
    );

    lid_div #(.NW(58), .DW(34), .QW(32), .SW(2)) u_xdiv (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (w_dtag.nxm),
        .i_den  (w_dtag.detm),
        .i_tag  ({w_dtag.sx, w_dtag.ovx}),
        .o_quot (w_qx),
        .o_tag  (w_xtag)
    );

    lid_div #(.NW(58), .DW(34), .QW(32), .SW(2)) u_ydiv (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (w_dtag.nym),
        .i_den  (w_dtag.detm),
        .i_tag  ({w_dtag.sy, w_dtag.ovy}),
        .o_quot (w_qy),
        .o_tag  (w_ytag)
    );

    always_comb begin
        w_ovfx = w_xtag[0] || (w_xtag[1] ? (w_qx > LID_NEG_MAX) : (w_qx > LID_POS_MAX));
        w_ovfy = w_ytag[0] || (w_ytag[1] ? (w_qy > LID_NEG_MAX) : (w_qy > LID_POS_MAX));
        if (w_stag[1]) begin
            w_cx = LID_POS_MAX;
            w_cy = LID_POS_MAX;
        end else begin
            w_cx = w_ovfx ? (w_xtag[1] ? LID_NEG_MAX : LID_POS_MAX)
                          : (w_xtag[1] ? 32'(-w_qx) : w_qx);
            w_cy = w_ovfy ? (w_ytag[1] ? LID_NEG_MAX : LID_POS_MAX)
                          : (w_ytag[1] ? 32'(-w_qy) : w_qy);
        end
        w_dist = w_stag[0] ? LID_U_MAX : w_root;
        w_ovf  = w_stag[0] || (!w_stag[1] && (w_ovfx || w_ovfy));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_data <= {6'd0, w_ovf, w_dist, w_stag[1], w_cy, w_cx};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_o_valid <= r_vld[LAT-1];
        end
    end

endmodule

// ===== tb/tb_line_intersect_and_distance.sv =====
`timescale 1ns / 100ps

module tb_line_intersect_and_distance;
    import lid_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 150;

    typedef struct {
        logic [31:0] cross_x;
        logic [31:0] cross_y;
        logic        parallel;
        logic [31:0] point_distance;
        logic        overflowed;
    } t_crossing;

    typedef logic signed [15:0] t_coords [10];

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [LID_IN_W-1:0]  s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [LID_OUT_W-1:0] m_axis_tdata;
    logic                 i_cfg_we;
    logic [31:0]          i_cfg_wdata;

    logic [31:0] tolerance_sq;
    t_crossing   pending_crossings[$];
    int          src_idle_pct;
    int          sink_idle_pct;
    int          error_count;
    int          quiet_cycles;

    line_intersect_and_distance i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void line_coefs(input longint x1, input longint y1, input longint x2,
                                       input longint y2, output longint a, output longint b,
                                       output longint c);
        if (x1 == x2) begin
            a = 256;
            b = 0;
            c = -x1 * 256;
        end else begin
            a = y2 - y1;
            b = x1 - x2;
            c = y1 * x2 - y2 * x1;
        end
    endfunction

    function automatic logic [31:0] sat_quotient(input longint numer, input longint den,
                                                 inout logic ovf);
        longint q;
        q = numer / den;
        if (q > 64'sd2147483647) begin
            ovf = 1'b1;
            return LID_POS_MAX;
        end
        if (q < -64'sd2147483648) begin
            ovf = 1'b1;
            return LID_NEG_MAX;
        end
        return q[31:0];
    endfunction

    function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = 0;
        for (int k = 31; k >= 0; k--) begin
            t = r | (64'd1 << k);
            if (t * t <= v) r = t;
        end
        return r[31:0];
    endfunction

    function automatic t_crossing predict_crossing(input t_coords v, input logic [31:0] tol);
        longint a1, b1, c1, a2, b2, c2, det, numer, mdet, mnum;
        logic [127:0] n1, n2, lhs, rhs, dsq;
        t_crossing r;
        line_coefs(v[0], v[1], v[2], v[3], a1, b1, c1);
        line_coefs(v[4], v[5], v[6], v[7], a2, b2, c2);
        n1 = 128'(a1 * a1 + b1 * b1);
        n2 = 128'(a2 * a2 + b2 * b2);
        det = a1 * b2 - a2 * b1;
        mdet = det < 0 ? -det : det;
        lhs = (128'(mdet) * 128'(mdet)) << 32;
        rhs = n1 * n2 * 128'(tol);
        r.overflowed = 1'b0;
        r.parallel = det == 0 || lhs < rhs;
        r.cross_x = LID_POS_MAX;
        r.cross_y = LID_POS_MAX;
        if (!r.parallel) begin
            r.cross_x = sat_quotient((b1 * c2 - b2 * c1) * 256, det, r.overflowed);
            r.cross_y = sat_quotient((c1 * a2 - c2 * a1) * 256, det, r.overflowed);
        end
        numer = a1 * v[8] + b1 * v[9] + c1;
        mnum = numer < 0 ? -numer : numer;
        dsq = ((128'(mnum) * 128'(mnum)) << 16) / n1;
        if (dsq[127:64] != 0) begin
            r.point_distance = LID_U_MAX;
            r.overflowed = 1'b1;
        end else begin
            r.point_distance = floor_sqrt(dsq[63:0]);
        end
        return r;
    endfunction

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        t_crossing want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_crossings.size() == 0) begin
                $error("result with no request outstanding: %h", m_axis_tdata);
                error_count++;
            end else begin
                want = pending_crossings.pop_front();
                if (m_axis_tdata[31:0] !== want.cross_x) begin
                    $error("cross_x exp %h got %h", want.cross_x, m_axis_tdata[31:0]);
                    error_count++;
                end
                if (m_axis_tdata[63:32] !== want.cross_y) begin
                    $error("cross_y exp %h got %h", want.cross_y, m_axis_tdata[63:32]);
                    error_count++;
                end
                if (m_axis_tdata[64] !== want.parallel) begin
                    $error("parallel exp %b got %b", want.parallel, m_axis_tdata[64]);
                    error_count++;
                end
                if (m_axis_tdata[96:65] !== want.point_distance) begin
                    $error("point_distance exp %h got %h", want.point_distance,
                           m_axis_tdata[96:65]);
                    error_count++;
                end
                if (m_axis_tdata[97] !== want.overflowed) begin
                    $error("overflowed exp %b got %b", want.overflowed, m_axis_tdata[97]);
                    error_count++;
                end
            end
        end
        if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_request(input t_coords v);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        for (int k = 0; k < 10; k++) s_axis_tdata[16*k +: 16] = v[k];
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_crossings.push_back(predict_crossing(v, tolerance_sq));
        @(negedge i_clk);
    endtask

    task automatic write_tolerance(input logic [31:0] value);
        s_axis_tvalid = 1'b0;
        wait (pending_crossings.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = value;
        tolerance_sq = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic signed [15:0] rand_coord(input bit narrow);
        int pick;
        pick = $urandom_range(19);
        if (pick == 0) return 16'sh8000;
        if (pick == 1) return 16'sh7FFF;
        if (narrow) return 16'($signed($urandom_range(2048)) - 1024);
        return 16'($urandom);
    endfunction

    function automatic t_coords make_request();
        t_coords v;
        bit narrow;
        int dx, dy;
        narrow = $urandom_range(1);
        foreach (v[k]) v[k] = rand_coord(narrow);
        case ($urandom_range(7))
            0: v[2] = v[0];
            1: v[6] = v[4];
            2: begin
                v[2] = v[0];
                v[3] = v[1];
            end
            3, 4: begin
                dx = v[2] - v[0];
                dy = v[3] - v[1];
                v[6] = 16'(v[4] + dx);
                v[7] = 16'(v[5] + dy);
            end
            5: begin
                dx = v[2] - v[0];
                dy = v[3] - v[1];
                v[6] = 16'(v[4] + dx + $signed($urandom_range(4)) - 2);
                v[7] = 16'(v[5] + dy + $signed($urandom_range(4)) - 2);
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic test_directed();
        send_request('{0, 0, 256, 0, 0, 0, 0, 256, 128, 128});
        send_request('{0, 0, 256, 256, 0, 256, 256, 0, -256, 512});
        send_request('{0, 0, 256, 256, 0, 0, 512, 512, 100, -100});
        send_request('{0, 0, 256, 256, 0, 256, 256, 512, 0, 0});
        send_request('{0, 0, 256, 5, 0, 256, 256, 261, 0, 0});
        send_request('{300, -50, 300, 900, -10, 0, 20, 40, 0, 0});
        send_request('{-7, -7, -7, -7, 3, 3, 3, 3, 32767, -32768});
        send_request('{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768,
                       32767, -32768});
        send_request('{-32768, -32768, 32767, 32766, -32768, -32767, 32767, 32767,
                       -32768, 32767});
        send_request('{32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768,
                       -32768, -32768});
        send_request('{-32768, 0, 32767, 0, 0, -32768, 0, 32767, -1, -1});
        send_request('{1, 0, 0, 1, 0, 0, 1, 1, -32768, 32767});
        send_request('{0, 0, 1, 0, 0, 0, 32767, 1, 0, 32767});
        send_request('{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1});
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++) send_request(make_request());
    endtask

    initial begin
        error_count = 0;
        quiet_cycles = 0;
        src_idle_pct = 12;
        sink_idle_pct = 71;
        tolerance_sq = LID_TOL_RESET;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(300);
        write_tolerance(32'd0);
        test_directed();
        test_random(200);

        src_idle_pct = 71;
        sink_idle_pct = 12;
        write_tolerance(32'hFFFF_FFFF);
        test_directed();
        test_random(300);
        write_tolerance($urandom);
        test_random(200);

        src_idle_pct = 0;
        sink_idle_pct = 0;
        write_tolerance($urandom_range(32'h0100_0000));
        test_random(300);
        write_tolerance(LID_TOL_RESET);
        test_random(300);

        s_axis_tvalid = 1'b0;
        wait (pending_crossings.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/lid_pkg.sv
design/lid_front.sv
design/lid_queue.sv
design/lid_div.sv
design/lid_sqrt.sv
design/lid_back.sv
design/line_intersect_and_distance.sv
tb/tb_line_intersect_and_distance.sv
